/* design/sobol_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sobol_pkg
// Shared types and constants for the Sobol point generator: word formats,
// configuration layout, controller states and the controller/datapath link.
// ----------------------------------------------------------------------------
package sobol_pkg;

    // default sizes of the direction and state stores
    localparam int MAX_DIMS_DEF   = 32;
    localparam int MAX_DIGITS_DEF = 32;

    // fixed field widths
    localparam int WORD_W     = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CNT6_W     = 6;
    localparam int BASE_W     = 16;
    localparam int SHIFT_W    = 4;

    // at most this many coordinates per point
    localparam int OUT_DIM_CAP = 32;

    // steps of the bit-serial divider
    localparam int DIV_STEPS = 32;

    // register reset values
    localparam logic [5:0]  NUM_DIGITS_RST  = 6'd32;
    localparam logic [15:0] DIGIT_BASE_RST  = 16'd2;
    localparam logic [31:0] SKIP_COUNT_RST  = 32'd0;
    localparam logic [5:0]  ACTIVE_DIMS_RST = 6'd32;

    // input word kinds
    typedef enum logic [1:0] {
        KIND_DIR     = 2'd0,
        KIND_START   = 2'd1,
        KIND_GEN     = 2'd2,
        KIND_RESTART = 2'd3
    } kind_t;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NUM_DIGITS  = 2'd0,
        CFG_DIGIT_BASE  = 2'd1,
        CFG_SKIP_COUNT  = 2'd2,
        CFG_ACTIVE_DIMS = 2'd3
    } cfg_idx_t;

    // controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_COL_RD,
        ST_COL_WR,
        ST_SRCH,
        ST_DIV,
        ST_GEN_RD,
        ST_GEN_WB
    } state_t;

    // input word
    typedef struct packed {
        logic [1:0]  kind;
        logic [4:0]  dim_select;
        logic [4:0]  digit_select;
        logic [31:0] load_word;
    } in_word_t;

    // result word
    typedef struct packed {
        logic [4:0]  out_dim;
        logic [31:0] coordinate;
        logic        last;
        logic        exhausted;
    } out_word_t;

    // configuration registers
    typedef struct packed {
        logic [5:0]  num_digits;
        logic [15:0] digit_base;
        logic [31:0] skip_count;
        logic [5:0]  active_dims;
    } cfg_t;

    // controller to datapath
    typedef struct packed {
        logic latch_in;
        logic start_wr;
        logic restart;
        logic col_rd;
        logic col_wr;
        logic search_init;
        logic set_exh;
        logic step_pow2;
        logic div_start;
        logic step_div;
        logic gen_rd;
        logic gen_wb;
        logic gen_next;
        logic count_inc;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        kind_t kind;
        logic  dim_ok;
        logic  digit_ok;
        logic  sweep_last;
        logic  k_full;
        logic  pow2;
        logic  pow2_match;
        logic  div_done;
        logic  div_match;
        logic  out_free;
        logic  gen_last;
    } status_t;

endpackage

/* design/sobol_sequence_generator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sobol_sequence_generator
// Generalized Sobol point generator with a base-P Gray-code style update.
// ----------------------------------------------------------------------------
// A generate word runs the digit search, then visits each active dimension
// in turn: the state memory is read, XORed and written back once a cycle
// while the result register drains, and the loop holds while that register
// is full. The search examines trailing digits of the point count one at
// a time, with a shift when the base is a power of two and a run of the
// bit-serial divider otherwise. A direction word load does one
// read-modify-write of each column of the selected dimension in the memory
// port. The stores come up undefined after reset and need no clearing pass;
// every active dimension must be loaded before the first generate word. The
// next word is accepted while the final coordinate still waits in the result
// register.
// ----------------------------------------------------------------------------
module sobol_sequence_generator #(
    parameter int MAX_DIMS   = sobol_pkg::MAX_DIMS_DEF,
    parameter int MAX_DIGITS = sobol_pkg::MAX_DIGITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  sobol_pkg::in_word_t                  s_data,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output sobol_pkg::out_word_t                 m_data,
    input  logic                                 cfg_we,
    input  logic [sobol_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sobol_pkg::WORD_W-1:0]         cfg_wdata
);

    sobol_pkg::cfg_t    cfg_reg;
    sobol_pkg::cmd_t    cmd;
    sobol_pkg::status_t status;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.num_digits  <= sobol_pkg::NUM_DIGITS_RST;
            cfg_reg.digit_base  <= sobol_pkg::DIGIT_BASE_RST;
            cfg_reg.skip_count  <= sobol_pkg::SKIP_COUNT_RST;
            cfg_reg.active_dims <= sobol_pkg::ACTIVE_DIMS_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                sobol_pkg::CFG_NUM_DIGITS:  cfg_reg.num_digits  <= cfg_wdata[5:0];
                sobol_pkg::CFG_DIGIT_BASE:  cfg_reg.digit_base  <= cfg_wdata[15:0];
                sobol_pkg::CFG_SKIP_COUNT:  cfg_reg.skip_count  <= cfg_wdata;
                sobol_pkg::CFG_ACTIVE_DIMS: cfg_reg.active_dims <= cfg_wdata[5:0];
                default: ;
            endcase
        end
    end

    // controller
    sobol_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // datapath
    sobol_dp #(
        .MAX_DIMS   (MAX_DIMS),
        .MAX_DIGITS (MAX_DIGITS)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .s_data  (s_data),
        .cmd     (cmd),
        .status  (status),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

/* design/sobol_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sobol_div
// Bit-serial restoring divider, 32-bit dividend by 16-bit divisor, one
// quotient bit per cycle. Used to peel one base digit off the point count.
// ----------------------------------------------------------------------------
module sobol_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [15:0] divisor,
    output logic [31:0] quot,
    output logic [15:0] rem,
    output logic        done
);

    logic [15:0] rem_reg;
    logic [31:0] quo_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;

    logic [16:0] trial;
    logic [16:0] diff;
    logic        ge;
    logic [15:0] rem_next;

    // one restoring step
    always_comb begin
        trial    = {rem_reg, quo_reg[31]};
        diff     = trial - {1'b0, divisor};
        ge       = (trial >= {1'b0, divisor});
        rem_next = ge ? diff[15:0] : trial[15:0];
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + 5'd1;
            if (cnt_reg == 5'(sobol_pkg::DIV_STEPS - 1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // remainder and quotient shift
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[30:0], ge};
        end
    end

    assign quot = quo_reg;
    assign rem  = rem_reg;
    assign done = done_reg;

endmodule

/* design/sobol_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sobol_dp
// Datapath: direction column memory, dimension state memory, point count,
// digit search registers with divider, coordinate forming and result register.
// ----------------------------------------------------------------------------
module sobol_dp #(
    parameter int MAX_DIMS   = sobol_pkg::MAX_DIMS_DEF,
    parameter int MAX_DIGITS = sobol_pkg::MAX_DIGITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  sobol_pkg::cfg_t      cfg,
    input  sobol_pkg::in_word_t  s_data,
    input  sobol_pkg::cmd_t      cmd,
    output sobol_pkg::status_t   status,
    output logic                 m_valid,
    input  logic                 m_ready,
    output sobol_pkg::out_word_t m_data
);

    localparam int DIM_W     = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int DIG_W     = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam int COL_DEPTH = MAX_DIMS * (1 << DIG_W);
    localparam int DIM_CAP   = (MAX_DIMS < sobol_pkg::OUT_DIM_CAP) ?
                               MAX_DIMS : sobol_pkg::OUT_DIM_CAP;

    // stores, undefined until loaded
    logic [MAX_DIGITS-1:0] col_mem [COL_DEPTH];
    logic [31:0]           st_mem  [MAX_DIMS];

    sobol_pkg::in_word_t  in_reg;
    sobol_pkg::out_word_t out_reg;
    logic                 out_valid_reg;
    logic [31:0]          count_reg;
    logic [DIG_W-1:0]     sk_reg;
    logic [5:0]           k_reg;
    logic [31:0]          rest_reg;
    logic                 exh_reg;
    logic [5:0]           i_reg;
    logic [MAX_DIGITS-1:0] col_q_reg;
    logic [31:0]          st_q_reg;

    logic [5:0]            ndig_eff;
    logic [5:0]            ndim_eff;
    logic [15:0]           base_eff;
    logic [15:0]           base_m1;
    logic [3:0]            base_sh;
    logic [5:0]            gen_dim;
    logic [DIM_W+DIG_W-1:0] col_addr;
    logic [MAX_DIGITS-1:0] ld_bits;
    logic [MAX_DIGITS-1:0] col_new;
    logic [DIM_W-1:0]      st_waddr;
    logic [31:0]           st_wdata;
    logic                  st_we;
    logic [31:0]           upd_state;
    logic [31:0]           rev_state;
    logic [63:0]           mask_wide;
    logic [31:0]           coord;
    logic                  gen_last;
    logic [31:0]           div_quot;
    logic [15:0]           div_rem;
    logic                  div_done;

    // clamp configuration to legal ranges
    always_comb begin
        if (cfg.num_digits == 6'd0) begin
            ndig_eff = 6'd1;
        end else if (cfg.num_digits > 6'(MAX_DIGITS)) begin
            ndig_eff = 6'(MAX_DIGITS);
        end else begin
            ndig_eff = cfg.num_digits;
        end
        if (cfg.active_dims == 6'd0) begin
            ndim_eff = 6'd1;
        end else if (cfg.active_dims > 6'(DIM_CAP)) begin
            ndim_eff = 6'(DIM_CAP);
        end else begin
            ndim_eff = cfg.active_dims;
        end
        base_eff = (cfg.digit_base < 16'd2) ? 16'd2 : cfg.digit_base;
        base_m1  = base_eff - 16'd1;
    end

    // shift amount for a power-of-two base
    always_comb begin
        base_sh = '0;
        for (int b = 0; b < sobol_pkg::BASE_W; b++) begin
            if (base_eff[b]) begin
                base_sh = 4'(b);
            end
        end
    end

    // digit divider for other bases
    sobol_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (rest_reg),
        .divisor  (base_eff),
        .quot     (div_quot),
        .rem      (div_rem),
        .done     (div_done)
    );

    // input word capture
    always_ff @(posedge aclk) begin
        if (cmd.latch_in) begin
            in_reg <= s_data;
        end
    end

    // point count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cmd.restart) begin
            count_reg <= cfg.skip_count;
        end else if (cmd.count_inc) begin
            count_reg <= count_reg + 32'd1;
        end
    end

    // sweep, search and dimension counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sk_reg  <= '0;
            k_reg   <= '0;
            i_reg   <= '0;
            exh_reg <= 1'b0;
        end else begin
            if (cmd.latch_in) begin
                sk_reg <= '0;
            end else if (cmd.col_wr) begin
                sk_reg <= sk_reg + DIG_W'(1);
            end
            if (cmd.search_init) begin
                k_reg   <= '0;
                i_reg   <= '0;
                exh_reg <= 1'b0;
            end else begin
                if (cmd.step_pow2 || cmd.step_div) begin
                    k_reg <= k_reg + 6'd1;
                end
                if (cmd.set_exh) begin
                    exh_reg <= 1'b1;
                end
                if (cmd.gen_next) begin
                    i_reg <= i_reg + 6'd1;
                end
            end
        end
    end

    // remaining count during the digit search
    always_ff @(posedge aclk) begin
        if (cmd.search_init) begin
            rest_reg <= count_reg;
        end else if (cmd.step_pow2) begin
            rest_reg <= rest_reg >> base_sh;
        end else if (cmd.step_div) begin
            rest_reg <= div_quot;
        end
    end

    // memory addressing
    always_comb begin
        gen_dim = cmd.gen_next ? (i_reg + 6'd1) : i_reg;
        if (cmd.col_rd || cmd.col_wr) begin
            col_addr = {DIM_W'(in_reg.dim_select), sk_reg};
        end else begin
            col_addr = {DIM_W'(gen_dim), DIG_W'(k_reg)};
        end
        ld_bits = in_reg.load_word[MAX_DIGITS-1:0];
        col_new = col_q_reg;
        col_new[in_reg.digit_select[DIG_W-1:0]] = ld_bits[sk_reg];
    end

    // direction column memory
    always_ff @(posedge aclk) begin
        if (cmd.col_wr) begin
            col_mem[col_addr] <= col_new;
        end
        if (cmd.col_rd || cmd.gen_rd || cmd.gen_next) begin
            col_q_reg <= col_mem[col_addr];
        end
    end

    // state update and coordinate
    always_comb begin
        upd_state = exh_reg ? st_q_reg : (st_q_reg ^ 32'(col_q_reg));
        for (int b = 0; b < sobol_pkg::WORD_W; b++) begin
            rev_state[sobol_pkg::WORD_W-1-b] = upd_state[b];
        end
        mask_wide = 64'hFFFF_FFFF_0000_0000 >> ndig_eff;
        coord     = rev_state & mask_wide[31:0];
        gen_last  = ((i_reg + 6'd1) == ndim_eff);
        st_we     = cmd.start_wr || (cmd.gen_wb && !exh_reg);
        st_waddr  = cmd.start_wr ? DIM_W'(in_reg.dim_select) : DIM_W'(i_reg);
        st_wdata  = cmd.start_wr ? in_reg.load_word : upd_state;
    end

    // dimension state memory
    always_ff @(posedge aclk) begin
        if (st_we) begin
            st_mem[st_waddr] <= st_wdata;
        end
        if (cmd.gen_rd || cmd.gen_next) begin
            st_q_reg <= st_mem[DIM_W'(gen_dim)];
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.gen_wb) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.gen_wb) begin
            out_reg.out_dim    <= 5'(i_reg);
            out_reg.coordinate <= coord;
            out_reg.last       <= gen_last;
            out_reg.exhausted  <= exh_reg;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    // status to the controller
    always_comb begin
        status.kind       = sobol_pkg::kind_t'(in_reg.kind);
        status.dim_ok     = (32'(in_reg.dim_select) < 32'(MAX_DIMS));
        status.digit_ok   = (32'(in_reg.digit_select) < 32'(MAX_DIGITS));
        status.sweep_last = (sk_reg == DIG_W'(MAX_DIGITS - 1));
        status.k_full     = (k_reg >= ndig_eff);
        status.pow2       = ((base_eff & base_m1) == 16'd0);
        status.pow2_match = ((rest_reg[15:0] & base_m1) == base_m1);
        status.div_done   = div_done;
        status.div_match  = (div_rem == base_m1);
        status.out_free   = !out_valid_reg || m_ready;
        status.gen_last   = gen_last;
    end

endmodule

/* design/sobol_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sobol_ctrl
// Controller: accepts input words and sequences column loads, the digit
// search and the per-dimension update loop through the datapath.
// ----------------------------------------------------------------------------
module sobol_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  sobol_pkg::status_t status,
    output sobol_pkg::cmd_t    cmd
);

    sobol_pkg::state_t state_reg;
    sobol_pkg::state_t state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sobol_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            sobol_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = sobol_pkg::ST_DECODE;
                end
            end
            sobol_pkg::ST_DECODE: begin
                case (status.kind)
                    sobol_pkg::KIND_DIR: begin
                        state_next = (status.dim_ok && status.digit_ok) ?
                                     sobol_pkg::ST_COL_RD : sobol_pkg::ST_IDLE;
                    end
                    sobol_pkg::KIND_GEN: state_next = sobol_pkg::ST_SRCH;
                    default:             state_next = sobol_pkg::ST_IDLE;
                endcase
            end
            sobol_pkg::ST_COL_RD: state_next = sobol_pkg::ST_COL_WR;
            sobol_pkg::ST_COL_WR: begin
                state_next = status.sweep_last ? sobol_pkg::ST_IDLE : sobol_pkg::ST_COL_RD;
            end
            sobol_pkg::ST_SRCH: begin
                if (status.k_full) begin
                    state_next = sobol_pkg::ST_GEN_RD;
                end else if (status.pow2) begin
                    if (!status.pow2_match) begin
                        state_next = sobol_pkg::ST_GEN_RD;
                    end
                end else begin
                    state_next = sobol_pkg::ST_DIV;
                end
            end
            sobol_pkg::ST_DIV: begin
                if (status.div_done) begin
                    state_next = status.div_match ? sobol_pkg::ST_SRCH : sobol_pkg::ST_GEN_RD;
                end
            end
            sobol_pkg::ST_GEN_RD: state_next = sobol_pkg::ST_GEN_WB;
            sobol_pkg::ST_GEN_WB: begin
                if (status.out_free && status.gen_last) begin
                    state_next = sobol_pkg::ST_IDLE;
                end
            end
            default: state_next = sobol_pkg::ST_IDLE;
        endcase
    end

    // commands
    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        case (state_reg)
            sobol_pkg::ST_IDLE: begin
                s_ready      = 1'b1;
                cmd.latch_in = s_valid;
            end
            sobol_pkg::ST_DECODE: begin
                case (status.kind)
                    sobol_pkg::KIND_START:   cmd.start_wr    = status.dim_ok;
                    sobol_pkg::KIND_RESTART: cmd.restart     = 1'b1;
                    sobol_pkg::KIND_GEN:     cmd.search_init = 1'b1;
                    default: ;
                endcase
            end
            sobol_pkg::ST_COL_RD: cmd.col_rd = 1'b1;
            sobol_pkg::ST_COL_WR: cmd.col_wr = 1'b1;
            sobol_pkg::ST_SRCH: begin
                if (status.k_full) begin
                    cmd.set_exh = 1'b1;
                end else if (status.pow2) begin
                    cmd.step_pow2 = status.pow2_match;
                end else begin
                    cmd.div_start = 1'b1;
                end
            end
            sobol_pkg::ST_DIV: begin
                cmd.step_div = status.div_done && status.div_match;
            end
            sobol_pkg::ST_GEN_RD: cmd.gen_rd = 1'b1;
            sobol_pkg::ST_GEN_WB: begin
                if (status.out_free) begin
                    cmd.gen_wb    = 1'b1;
                    cmd.count_inc = status.gen_last;
                    cmd.gen_next  = !status.gen_last;
                end
            end
            default: ;
        endcase
    end

endmodule

/* bench/sobol_sequence_generator_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sobol_sequence_generator_tb
// Self-checking bench for the Sobol point generator. Every direction column
// and start word is loaded first. A short directed run then covers the
// register extremes, exhausted points and count wrap. Random runs under
// three source/sink idling mixes follow. A scoreboard predicts every
// coordinate and checks the result words in order.
// ----------------------------------------------------------------------------
module sobol_sequence_generator_tb;
    import sobol_pkg::*;

    localparam int HALF_PERIOD  = 5;
    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int QUIET_CYCLES = 100;
    localparam int HOLD_CYCLES  = 1500;

    // predicts coordinates and checks result words in arrival order
    class sobol_scoreboard;
        logic [31:0] dir_column [MAX_DIMS_DEF][MAX_DIGITS_DEF];
        logic [31:0] dim_word [MAX_DIMS_DEF];
        logic [31:0] point_cnt;
        logic [5:0]  num_digits;
        logic [15:0] digit_base;
        logic [31:0] skip_count;
        logic [5:0]  active_dims;
        out_word_t   coord_q [$];
        int          errors;

        function new();
            foreach (dir_column[d, k]) dir_column[d][k] = '0;
            foreach (dim_word[d]) dim_word[d] = '0;
            point_cnt   = '0;
            num_digits  = NUM_DIGITS_RST;
            digit_base  = DIGIT_BASE_RST;
            skip_count  = SKIP_COUNT_RST;
            active_dims = ACTIVE_DIMS_RST;
            errors      = 0;
        endfunction

        function void write_reg(cfg_idx_t idx, logic [31:0] value);
            case (idx)
                CFG_NUM_DIGITS:  num_digits  = value[5:0];
                CFG_DIGIT_BASE:  digit_base  = value[15:0];
                CFG_SKIP_COUNT:  skip_count  = value;
                CFG_ACTIVE_DIMS: active_dims = value[5:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return coord_q.size();
        endfunction

        // update the model state for one accepted input word
        function void note_word(in_word_t w);
            int unsigned base, ndig, ndim, k;
            logic [31:0] rest, frac;
            bit          spent;
            out_word_t   c;
            case (w.kind)
                KIND_DIR: begin
                    // bit b of the word lands in bit digit_select of column b
                    for (int b = 0; b < MAX_DIGITS_DEF; b++)
                        dir_column[w.dim_select][b][w.digit_select] = w.load_word[b];
                end
                KIND_START: dim_word[w.dim_select] = w.load_word;
                KIND_RESTART: point_cnt = skip_count;
                default: begin
                    // out-of-range registers are clamped
                    base = (digit_base < 2) ? 2 : digit_base;
                    ndig = (num_digits == 0) ? 1 :
                           (num_digits > MAX_DIGITS_DEF) ? MAX_DIGITS_DEF : num_digits;
                    ndim = (active_dims == 0) ? 1 :
                           (active_dims > MAX_DIMS_DEF) ? MAX_DIMS_DEF : active_dims;
                    // count trailing digits equal to base-1
                    rest = point_cnt;
                    k = 0;
                    while (k < 33 && rest % base == base - 1) begin
                        k++;
                        rest = rest / base;
                    end
                    spent = (k >= ndig);
                    for (int d = 0; d < ndim; d++) begin
                        if (!spent)
                            dim_word[d] ^= dir_column[d][k];
                        // reversed digits, top aligned
                        frac = '0;
                        for (int j = 0; j < ndig; j++)
                            frac[31 - j] = dim_word[d][j];
                        c.out_dim    = 5'(d);
                        c.coordinate = frac;
                        c.last       = (d == ndim - 1);
                        c.exhausted  = spent;
                        coord_q.push_back(c);
                    end
                    point_cnt++;
                end
            endcase
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
            end
        endfunction

        function void check_result(out_word_t got);
            out_word_t want;
            if (coord_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected word, expected none, got dim %0d coord %h",
                         $time, got.out_dim, got.coordinate);
                return;
            end
            want = coord_q.pop_front();
            compare_field("out_dim", want.out_dim, got.out_dim);
            compare_field("coordinate", want.coordinate, got.coordinate);
            compare_field("last", want.last, got.last);
            compare_field("exhausted", want.exhausted, got.exhausted);
        endfunction
    endclass

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    in_word_t             s_data    = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    out_word_t            m_data;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [WORD_W-1:0]    cfg_wdata = '0;

    sobol_scoreboard sb = new();

    int          src_idle  = 0;
    int          dst_idle  = 0;
    int          hold_req  = 0;
    int          hold_seen = 0;
    int          hold_left = 0;
    int unsigned cycle_cnt = 0;

    sobol_sequence_generator i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #(HALF_PERIOD) aclk = ~aclk;

    // sink: check accepted words, random stalls and long hold-offs
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready)
                sb.check_result(m_data);
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= dst_idle);
            end
        end
    end

    // watchdog
    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_cnt++;
        end
        $display("end of test: mismatches");
        $finish;
    end

    function automatic in_word_t make_word(kind_t kind, logic [4:0] dim,
                                           logic [4:0] digit, logic [31:0] value);
        in_word_t w;
        w.kind         = kind;
        w.dim_select   = dim;
        w.digit_select = digit;
        w.load_word    = value;
        return w;
    endfunction

    // offer one word, valid stays high after acceptance
    task automatic send_word(in_word_t w);
        while ($urandom_range(99) < src_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        sb.note_word(w);
    endtask

    task automatic send_gen();
        send_word(make_word(KIND_GEN, 5'($urandom), 5'($urandom), $urandom));
    endtask

    task automatic send_restart();
        send_word(make_word(KIND_RESTART, 5'($urandom), 5'($urandom), $urandom));
    endtask

    // stop offering until every expected word has arrived
    task automatic drain_results();
        s_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge aclk);
        @(posedge aclk);
    endtask

    // drain and let a pending direction load finish
    task automatic settle();
        drain_results();
        repeat (QUIET_CYCLES) @(posedge aclk);
    endtask

    task automatic put_reg(cfg_idx_t idx, logic [31:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        sb.write_reg(idx, value);
    endtask

    task automatic set_config(logic [31:0] nd, logic [31:0] base,
                              logic [31:0] skip, logic [31:0] dims);
        put_reg(CFG_NUM_DIGITS, nd);
        put_reg(CFG_DIGIT_BASE, base);
        put_reg(CFG_SKIP_COUNT, skip);
        put_reg(CFG_ACTIVE_DIMS, dims);
        cfg_we <= 1'b0;
    endtask

    // random setting, mostly legal, sometimes clamped
    task automatic random_config();
        logic [31:0] nd, base, skip, dims;
        case ($urandom_range(9))
            0:       nd = 0;
            1:       nd = $urandom_range(33, 63);
            2:       nd = $urandom_range(1, 6);
            default: nd = $urandom_range(1, 32);
        endcase
        case ($urandom_range(7))
            0:       base = 2;
            1:       base = 32'd1 << $urandom_range(2, 15);
            2:       base = $urandom_range(0, 1);
            3:       base = 65535;
            4:       base = $urandom_range(3, 10);
            default: base = $urandom_range(2, 65535);
        endcase
        case ($urandom_range(5))
            0:       skip = $urandom;
            1:       skip = 0;
            2:       skip = 32'hFFFF_FFFF - $urandom_range(0, 3);
            default: skip = $urandom_range(0, 1000);
        endcase
        case ($urandom_range(7))
            0:       dims = 0;
            1:       dims = $urandom_range(33, 63);
            2:       dims = 32;
            default: dims = $urandom_range(1, 12);
        endcase
        set_config(nd, base, skip, dims);
    endtask

    // mostly points, with table rewrites and restarts mixed in
    task automatic random_items(int n);
        int r;
        repeat (n) begin
            r = $urandom_range(99);
            if (r < 60)
                send_gen();
            else if (r < 68)
                send_restart();
            else if (r < 80)
                send_word(make_word(KIND_START, 5'($urandom), 5'($urandom), $urandom));
            else
                send_word(make_word(KIND_DIR, 5'($urandom), 5'($urandom), $urandom));
            if ($urandom_range(99) < 2)
                drain_results();
        end
    endtask

    task automatic random_phase(int n, bit with_hold);
        settle();
        random_config();
        if (with_hold)
            hold_req++;
        random_items(n);
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        src_idle = 31;
        dst_idle = 68;
        set_config(32, 2, 0, 32);

        // fill every start word and every bit of every column
        for (int d = 0; d < MAX_DIMS_DEF; d++)
            send_word(make_word(KIND_START, 5'(d), 5'($urandom), $urandom));
        for (int d = 0; d < MAX_DIMS_DEF; d++)
            for (int j = 0; j < MAX_DIGITS_DEF; j++)
                send_word(make_word(KIND_DIR, 5'(d), 5'(j), $urandom));

        // field extremes under the reset setting
        send_gen();
        send_gen();
        send_gen();
        send_word(make_word(KIND_DIR, 5'd31, 5'd31, 32'hFFFF_FFFF));
        send_word(make_word(KIND_DIR, 5'd0, 5'd0, 32'h0));
        send_word(make_word(KIND_START, 5'd0, 5'd31, 32'h0));
        send_word(make_word(KIND_START, 5'd31, 5'd0, 32'hFFFF_FFFF));
        send_gen();

        // zero digit count, base one, zero dims: exhausted, wrap, exhausted
        settle();
        set_config(0, 1, 32'hFFFF_FFFF, 0);
        send_restart();
        send_gen();
        send_gen();
        send_gen();

        // oversized digit and dim counts, base zero, wrap at full width
        settle();
        set_config(63, 0, 32'hFFFF_FFFE, 63);
        send_restart();
        send_gen();
        send_gen();
        send_gen();

        // largest base, two trailing top digits
        settle();
        set_config(32, 65535, 32'hFFFE_0000, 33);
        send_restart();
        send_gen();
        send_gen();

        // base three runs out of digits, then restarts the search
        settle();
        set_config(5, 3, 242, 1);
        send_restart();
        send_gen();
        send_gen();

        // random runs under three idling mixes
        random_phase(30, 1'b1);
        random_phase(30, 1'b0);
        random_phase(30, 1'b0);
        random_phase(30, 1'b0);

        src_idle = 68;
        dst_idle = 31;
        random_phase(30, 1'b0);
        random_phase(30, 1'b0);
        random_phase(30, 1'b0);
        random_phase(30, 1'b0);

        src_idle = 0;
        dst_idle = 0;
        random_phase(30, 1'b0);
        random_phase(30, 1'b0);
        random_phase(30, 1'b0);
        random_phase(30, 1'b1);

        // wait for the tail, then report
        s_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge aclk);
        repeat (QUIET_CYCLES) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
